### hdl/slrp_pkg.sv
// Package for the serial line to report packer.
// Holds default sizes, byte codes, operation codes and the FIFO control type.
// No dependencies.
`default_nettype none

package slrp_pkg;

    localparam int REPORT_BYTES_DEF = 8;
    localparam int FIFO_DEPTH_DEF   = 128;

    localparam logic [7:0] CODE_CR = 8'd13;
    localparam logic [7:0] CODE_LF = 8'd10;

    localparam logic OP_SERIAL = 1'b0;
    localparam logic OP_REPORT = 1'b1;

    typedef struct packed {
        logic push;
        logic pop;
    } fifo_ctl_t;

endpackage

`default_nettype wire

### hdl/slrp_line_mem.sv
// Line store: one write port, one read port with registered read data.
// Depends on nothing but its parameters.
`default_nettype none

module slrp_line_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic          clk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/slrp_fifo.sv
// Byte FIFO held in a synchronous memory, with read and write indexes and a count.
// Pushes that find it full are dropped. Uses slrp_pkg::fifo_ctl_t.
`default_nettype none

module slrp_fifo #(
    parameter int DEPTH = 128,
    parameter int CW    = 8
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire slrp_pkg::fifo_ctl_t ctl,
    input  wire logic [7:0]          wdata,
    output logic      [7:0]          rdata,
    output logic      [CW-1:0]       count
);

    localparam int IW = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [IW-1:0] rd_idx_reg;
    logic [IW-1:0] rd_idx_next;
    logic [IW-1:0] wr_idx_reg;
    logic [IW-1:0] wr_idx_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;

    assign do_push = ctl.push && (count_reg < CW'(DEPTH));
    assign count   = count_reg;

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        wr_idx_next = wr_idx_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_idx_next = (wr_idx_reg == IW'(DEPTH - 1)) ? '0 : wr_idx_reg + 1'b1;
            count_next  = count_reg + 1'b1;
        end
        else if (ctl.pop)
        begin
            rd_idx_next = (rd_idx_reg == IW'(DEPTH - 1)) ? '0 : rd_idx_reg + 1'b1;
            count_next  = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_idx_reg <= '0;
            wr_idx_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_idx_reg] <= wdata;
        end
        if (ctl.pop)
        begin
            rdata <= mem[rd_idx_reg];
        end
    end

endmodule

`default_nettype wire

### hdl/slrp_report_mem.sv
// Report store: synchronous memory with per-entry valid bits so that
// entries never written read as zero after reset. Read data is registered
// and held while re is low. No package dependencies.
`default_nettype none

module slrp_report_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [7:0]       rd_reg;
    logic             rd_valid_reg;

    assign rdata = rd_valid_reg ? rd_reg : 8'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_reg <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/serial_line_to_report_packer_unit.sv
// Serial line to report packer, top level.
// Depends on slrp_pkg, slrp_line_mem, slrp_fifo and slrp_report_mem.
//
// Input channel (in_valid/in_ready) carries one item: a received serial byte
// (operation 0) or a host request for a report (operation 1), plus the link
// state. Output channel (out_valid/out_ready) carries report bytes, last_byte
// marks the final one.
// A serial byte that ends a line (zero or full line store) has the line
// copied into the FIFO at one byte per cycle through the line store read port.
// A report request with the link up and bytes in the FIFO pops up to
// REPORT_BYTES-1 bytes through the FIFO read port, writes the closing zero,
// then reads REPORT_BYTES report bytes, one per cycle while the receiver
// takes them.
// The report store read register is the output register: a stalled receiver
// holds the byte and pauses the read sequence. The next item is accepted as
// soon as the last report byte has been read out, even if it is not yet taken.
// Reset clears the line fill, FIFO indexes and count, and the report store
// valid bits (the report reads as zeros); no clearing pass is needed.
`default_nettype none

module serial_line_to_report_packer_unit #(
    parameter int REPORT_BYTES = slrp_pkg::REPORT_BYTES_DEF,
    parameter int FIFO_DEPTH   = slrp_pkg::FIFO_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       operation,
    input  wire logic [7:0] rx_byte,
    input  wire logic       link_configured,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic      [7:0] report_byte,
    output logic            last_byte
);

    localparam int AW  = $clog2(REPORT_BYTES);
    localparam int NW  = $clog2(REPORT_BYTES + 1);
    localparam int FCW = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FLUSH = 2'd1;
    localparam logic [1:0] ST_MOVE  = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    logic [1:0]    state_reg;
    logic [1:0]    state_next;
    logic [NW-1:0] fill_reg;
    logic [NW-1:0] fill_next;
    logic [NW-1:0] cnt_reg;
    logic [NW-1:0] cnt_next;
    logic [NW-1:0] lim_reg;
    logic [NW-1:0] lim_next;
    logic          fl_pend_reg;
    logic          fl_pend_next;
    logic          mv_pend_reg;
    logic          mv_pend_next;
    logic [AW-1:0] mv_idx_reg;
    logic [AW-1:0] mv_idx_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          last_reg;
    logic          last_next;

    logic          accept;
    logic [7:0]    clean_byte;
    logic [NW-1:0] fill_inc;

    logic          line_we;
    logic          line_re;
    logic [7:0]    line_rdata;

    slrp_pkg::fifo_ctl_t fifo_ctl;
    logic [7:0]          fifo_rdata;
    logic [FCW-1:0]      fifo_count;

    logic          rep_we;
    logic [AW-1:0] rep_waddr;
    logic [7:0]    rep_wdata;
    logic          rep_re;

    assign accept     = in_valid && in_ready;
    assign in_ready   = (state_reg == ST_IDLE);
    assign clean_byte = (rx_byte == slrp_pkg::CODE_CR) ? 8'd0 : rx_byte;
    assign fill_inc   = fill_reg + 1'b1;
    assign out_valid  = out_valid_reg;
    assign last_byte  = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        cnt_next       = cnt_reg;
        lim_next       = lim_reg;
        fl_pend_next   = 1'b0;
        mv_pend_next   = 1'b0;
        mv_idx_next    = mv_idx_reg;
        last_next      = last_reg;
        line_we        = 1'b0;
        line_re        = 1'b0;
        fifo_ctl.push  = fl_pend_reg;
        fifo_ctl.pop   = 1'b0;
        rep_we         = mv_pend_reg;
        rep_waddr      = mv_idx_reg;
        rep_wdata      = fifo_rdata;
        rep_re         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && operation == slrp_pkg::OP_SERIAL)
                begin
                    // drop line feeds and bytes seen while the link is down
                    if (rx_byte != slrp_pkg::CODE_LF && link_configured)
                    begin
                        line_we = 1'b1;
                        if (clean_byte == 8'd0 || fill_inc == NW'(REPORT_BYTES))
                        begin
                            lim_next   = fill_inc;
                            cnt_next   = '0;
                            fill_next  = '0;
                            state_next = ST_FLUSH;
                        end
                        else
                        begin
                            fill_next = fill_inc;
                        end
                    end
                end
                else if (accept && link_configured && fifo_count != '0)
                begin
                    if (32'(fifo_count) >= 32'(REPORT_BYTES - 1))
                    begin
                        lim_next = NW'(REPORT_BYTES - 1);
                    end
                    else
                    begin
                        lim_next = NW'(fifo_count);
                    end
                    cnt_next   = '0;
                    state_next = ST_MOVE;
                end
            end
            ST_FLUSH:
            begin
                if (cnt_reg < lim_reg)
                begin
                    line_re      = 1'b1;
                    fl_pend_next = 1'b1;
                    cnt_next     = cnt_reg + 1'b1;
                end
                else
                begin
                    // last read still lands in the FIFO this cycle
                    state_next = ST_IDLE;
                end
            end
            ST_MOVE:
            begin
                if (cnt_reg < lim_reg)
                begin
                    fifo_ctl.pop = 1'b1;
                    mv_pend_next = 1'b1;
                    mv_idx_next  = cnt_reg[AW-1:0];
                    cnt_next     = cnt_reg + 1'b1;
                end
                else if (!mv_pend_reg)
                begin
                    // close the report with a zero
                    rep_we     = 1'b1;
                    rep_waddr  = lim_reg[AW-1:0];
                    rep_wdata  = 8'd0;
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    rep_re    = 1'b1;
                    last_next = (cnt_reg == NW'(REPORT_BYTES - 1));
                    cnt_next  = cnt_reg + 1'b1;
                    if (cnt_reg == NW'(REPORT_BYTES - 1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (rep_re)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            cnt_reg       <= '0;
            lim_reg       <= '0;
            fl_pend_reg   <= 1'b0;
            mv_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            cnt_reg       <= cnt_next;
            lim_reg       <= lim_next;
            fl_pend_reg   <= fl_pend_next;
            mv_pend_reg   <= mv_pend_next;
            out_valid_reg <= out_valid_next;
            last_reg      <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mv_idx_reg <= mv_idx_next;
    end

    slrp_line_mem #(
        .DEPTH (REPORT_BYTES),
        .AW    (AW)
    ) u_line (
        .clk   (clk),
        .we    (line_we),
        .waddr (fill_reg[AW-1:0]),
        .wdata (clean_byte),
        .re    (line_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (line_rdata)
    );

    slrp_fifo #(
        .DEPTH (FIFO_DEPTH),
        .CW    (FCW)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (fifo_ctl),
        .wdata (line_rdata),
        .rdata (fifo_rdata),
        .count (fifo_count)
    );

    slrp_report_mem #(
        .DEPTH (REPORT_BYTES),
        .AW    (AW)
    ) u_report (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (rep_we),
        .waddr (rep_waddr),
        .wdata (rep_wdata),
        .re    (rep_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (report_byte)
    );

endmodule

`default_nettype wire

### hdl/slrp_checker.sv
// Port-level checks for the serial line to report packer, and the bind
// that attaches them to serial_line_to_report_packer_unit. Uses slrp_pkg.
`default_nettype none

module slrp_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       in_valid,
    input wire logic       in_ready,
    input wire logic       operation,
    input wire logic       out_valid,
    input wire logic       out_ready,
    input wire logic [7:0] report_byte,
    input wire logic       last_byte
);

    // a stalled report byte holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(report_byte) && $stable(last_byte))
        else $error("report byte changed while stalled");

    // a serial item taken with no report pending causes no output
    a_serial_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && operation == slrp_pkg::OP_SERIAL && !out_valid |=> !out_valid)
        else $error("serial item produced output");

    // once a report byte other than the last is taken, the next one follows at once
    a_report_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last_byte |=> out_valid)
        else $error("gap inside a report");

    // no new item while a report is partly sent
    a_busy_mid_report: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_byte |-> !in_ready)
        else $error("input taken in the middle of a report");

endmodule

bind serial_line_to_report_packer_unit slrp_checker u_slrp_checker (.*);

`default_nettype wire
